// ===== rtl/core/bcj2_branch_decoder_defines.svh =====
// Assertion macros shared by the branch decoder RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef BCJ2_BRANCH_DECODER_DEFINES_SVH
`define BCJ2_BRANCH_DECODER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define BCJ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define BCJ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bcj_pkg.sv =====
// Package for the branch decoder: opcodes, stream codes, status codes, queue word type.
// No dependencies.
package bcj_pkg;
  localparam logic [1:0] OP_MAIN = 2'd0;
  localparam logic [1:0] OP_RANGE = 2'd1;
  localparam logic [1:0] OP_WORD = 2'd2;

  localparam logic [1:0] STR_MAIN = 2'd0;
  localparam logic [1:0] STR_RANGE = 2'd1;
  localparam logic [1:0] STR_CALL = 2'd2;
  localparam logic [1:0] STR_JUMP = 2'd3;

  localparam logic [2:0] ST_RUN = 3'd0;
  localparam logic [2:0] ST_DONE = 3'd1;
  localparam logic [2:0] ST_PROLOGUE = 3'd2;
  localparam logic [2:0] ST_OVERRUN = 3'd3;
  localparam logic [2:0] ST_OPCODE = 3'd4;

  localparam logic [31:0] TOP_LIMIT = 32'h0100_0000;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] in_byte;
    logic [31:0] target_word;
  } item_t;

  typedef struct packed {
    logic [31:0] val;
    logic [7:0] first_byte;
    logic four;
    logic valid;
    logic [1:0] need;
    logic [2:0] status;
  } res_t;
endpackage

// ===== rtl/core/bcj_core.sv =====
// Front part: accepts input words and runs the range decoder and bookkeeping.
// Also holds bcj_ram, the registered-read RAM that keeps the probability table.
// Depends on bcj_pkg; emits one result record per word into the result queue.
module bcj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

module bcj_core #(
  parameter int PROB_BITS = 11,
  parameter int MOVE_BITS = 5
) (
  input  logic clk,
  input  logic rst,
  input  logic [31:0] output_length,
  input  logic in_valid,
  output logic in_ready,
  input  bcj_pkg::item_t item,
  output logic res_valid,
  input  logic res_room,
  output bcj_pkg::res_t res
);
  import bcj_pkg::*;
  `include "bcj2_branch_decoder_defines.svh"

  localparam int NCTX = 258;
  localparam int CW = 9;
  localparam logic [PROB_BITS:0] PHALF = (PROB_BITS + 1)'(1) << (PROB_BITS - 1);
  localparam logic [PROB_BITS:0] PFULL = (PROB_BITS + 1)'(1) << PROB_BITS;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_MUL   = 4'b0100,
    S_CMP   = 4'b1000
  } dec_state_t;

  dec_state_t state;
  logic [CW-1:0] clr_addr;

  logic [31:0] coder_range, coder_value, ip, emitted;
  logic [7:0] prev;
  logic [2:0] pro_cnt;
  logic [CW-1:0] pend_ctx;
  logic pend_call;
  logic [1:0] awaited;
  logic err;
  logic [2:0] err_kind;

  // Bit decode: the table read and the multiply are each registered before the compare.
  logic [31:0] bound;
  logic [CW-1:0] d_ctx;
  logic d_call;
  logic [PROB_BITS:0] d_p;
  logic [31:0] d_range, d_value;
  logic d_out_valid;
  logic [7:0] d_byte;

  logic fire;
  logic finished;
  logic [1:0] expected;
  logic cand;
  logic [CW-1:0] ctx;
  logic [PROB_BITS:0] p_rd;
  logic [31:0] ip4, val;
  logic [31:0] remain;
  logic [31:0] nr, nv;
  logic [CW-1:0] sel_ctx;
  logic [1:0] fin_need;
  logic bit0;
  logic [PROB_BITS:0] p_new;
  logic ram_we;
  logic [CW-1:0] ram_waddr;
  logic [PROB_BITS:0] ram_wdata;

  assign in_ready = (state == S_IDLE) && res_room;
  assign fire = in_valid && in_ready;
  assign finished = (output_length == 32'd0) ||
                    (awaited == STR_MAIN && emitted >= output_length);
  assign expected = (awaited == STR_CALL || awaited == STR_JUMP) ? OP_WORD : awaited;
  assign cand = (item.in_byte[7:1] == 7'h74) ||
                (prev == 8'h0F && item.in_byte[7:4] == 4'h8);
  always_comb begin
    if (item.in_byte == 8'hE8) begin
      ctx = CW'(prev) + CW'(2);
    end else if (item.in_byte == 8'hE9) begin
      ctx = CW'(1);
    end else begin
      ctx = '0;
    end
  end
  assign ip4 = ip + 32'd4;
  assign val = item.target_word - ip4;
  assign remain = output_length - emitted;
  assign nr = (awaited == STR_RANGE) ? {coder_range[23:0], 8'h00} : coder_range;
  assign nv = (awaited == STR_RANGE) ? {coder_value[23:0], item.in_byte} : coder_value;

  assign sel_ctx = (awaited == STR_RANGE) ? pend_ctx : ctx;

  assign bit0 = d_value < bound;
  assign fin_need = bit0 ? STR_MAIN : (d_call ? STR_CALL : STR_JUMP);
  assign p_new = bit0 ? d_p + ((PFULL - d_p) >> MOVE_BITS) : d_p - (d_p >> MOVE_BITS);

  assign ram_we = (state == S_CLEAR) || (state == S_CMP);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : d_ctx;
  assign ram_wdata = (state == S_CLEAR) ? PHALF : p_new;

  bcj_ram #(.WIDTH(PROB_BITS + 1), .DEPTH(NCTX)) u_prob (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(sel_ctx), .rdata(p_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      coder_range <= '1;
      coder_value <= '0;
      ip <= '0;
      emitted <= '0;
      prev <= '0;
      pro_cnt <= '0;
      pend_ctx <= '0;
      pend_call <= 1'b0;
      awaited <= STR_RANGE;
      err <= 1'b0;
      err_kind <= ST_RUN;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + CW'(1);
        if (clr_addr == CW'(NCTX - 1)) begin
          state <= S_IDLE;
        end
      end else if (state == S_MUL) begin
        bound <= 32'(d_range[31:PROB_BITS]) * 32'(p_rd);
        d_p <= p_rd;
        state <= S_CMP;
      end else if (state == S_CMP) begin
        state <= S_IDLE;
        awaited <= fin_need;
        if (bit0) begin
          coder_range <= bound;
          coder_value <= d_value;
        end else begin
          coder_range <= d_range - bound;
          coder_value <= d_value - bound;
        end
        res_valid <= 1'b1;
        res.val <= '0;
        res.four <= 1'b0;
        res.first_byte <= d_byte;
        res.valid <= d_out_valid;
        res.need <= fin_need;
        res.status <= ((fin_need == STR_MAIN) &&
                       (output_length == 32'd0 || emitted >= output_length)) ? ST_DONE : ST_RUN;
      end else if (fire) begin
        res_valid <= 1'b1;
        res.val <= '0;
        res.four <= 1'b0;
        res.first_byte <= '0;
        res.valid <= 1'b0;
        res.need <= awaited;
        if (err) begin
          res.status <= err_kind;
        end else if (finished) begin
          res.status <= ST_DONE;
        end else if (item.opcode != expected) begin
          err <= 1'b1;
          err_kind <= ST_OPCODE;
          res.status <= ST_OPCODE;
        end else if (awaited == STR_RANGE && pro_cnt < 3'd5) begin
          res.status <= ST_RUN;
          if (pro_cnt == 3'd0 && item.in_byte != 8'd0) begin
            err <= 1'b1;
            err_kind <= ST_PROLOGUE;
            res.status <= ST_PROLOGUE;
          end else begin
            pro_cnt <= pro_cnt + 3'd1;
            if (pro_cnt != 3'd0) begin
              coder_value <= nv;
            end
            if (pro_cnt == 3'd4) begin
              if (nv == 32'hFFFF_FFFF) begin
                err <= 1'b1;
                err_kind <= ST_PROLOGUE;
                res.status <= ST_PROLOGUE;
              end else begin
                coder_range <= '1;
                awaited <= STR_MAIN;
                res.need <= STR_MAIN;
                res.status <= (output_length == 32'd0 || emitted >= output_length)
                              ? ST_DONE : ST_RUN;
              end
            end
          end
        end else if (awaited == STR_RANGE) begin
          res_valid <= 1'b0;
          state <= S_MUL;
          d_ctx <= pend_ctx;
          d_call <= pend_call;
          d_range <= nr;
          d_value <= nv;
          d_out_valid <= 1'b0;
          d_byte <= '0;
        end else if (awaited == STR_MAIN) begin
          emitted <= emitted + 32'd1;
          ip <= ip + 32'd1;
          prev <= item.in_byte;
          res.first_byte <= item.in_byte;
          res.valid <= 1'b1;
          res.status <= (emitted + 32'd1 >= output_length) ? ST_DONE : ST_RUN;
          if (cand) begin
            if (coder_range < TOP_LIMIT) begin
              awaited <= STR_RANGE;
              res.need <= STR_RANGE;
              res.status <= ST_RUN;
              pend_ctx <= ctx;
              pend_call <= (item.in_byte == 8'hE8);
            end else begin
              res_valid <= 1'b0;
              state <= S_MUL;
              d_ctx <= ctx;
              d_call <= (item.in_byte == 8'hE8);
              d_range <= coder_range;
              d_value <= coder_value;
              d_out_valid <= 1'b1;
              d_byte <= item.in_byte;
            end
          end
        end else begin
          ip <= ip4;
          if (emitted > output_length || remain < 32'd4) begin
            err <= 1'b1;
            err_kind <= ST_OVERRUN;
            res.status <= ST_OVERRUN;
          end else begin
            emitted <= emitted + 32'd4;
            prev <= val[31:24];
            awaited <= STR_MAIN;
            res.need <= STR_MAIN;
            res.val <= val;
            res.four <= 1'b1;
            res.valid <= 1'b1;
            res.status <= (emitted + 32'd4 >= output_length) ? ST_DONE : ST_RUN;
          end
        end
      end
    end
  end

  `BCJ_ASSERT_NEXT(a_mul_then_cmp, clk, rst, state == S_MUL, state == S_CMP, "multiply not followed by compare")
  `BCJ_ASSERT_IMP(a_no_take_busy, clk, rst, state != S_IDLE, !in_ready, "input taken during decode")
  `BCJ_ASSERT_NEXT(a_err_sticky, clk, rst, err, err, "error flag cleared")
endmodule

// ===== rtl/core/bcj_back.sv =====
// Back part: a small result queue and a serializer that splits word results into bytes.
// Depends on bcj_pkg; feeds the master-side stream of the top level.
module bcj_back (
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  output logic res_room,
  input  bcj_pkg::res_t res,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [7:0] m_byte,
  output logic m_out_valid,
  output logic m_last,
  output logic [1:0] m_need,
  output logic [2:0] m_status
);
  import bcj_pkg::*;
  `include "bcj2_branch_decoder_defines.svh"

  res_t q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic [1:0] sub;
  logic pop;
  res_t h;

  assign h = q[rp];
  // Room for a result even when one more lands before the count updates.
  assign res_room = cnt <= 3'd2;
  assign m_tvalid = cnt != 3'd0;
  assign m_byte = h.four ? h.val[8*sub +: 8] : h.first_byte;
  assign m_out_valid = h.valid;
  assign m_last = !h.four || sub == 2'd3;
  assign m_need = h.need;
  assign m_status = h.status;
  assign pop = m_tvalid && m_tready && m_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
      sub <= '0;
    end else begin
      if (res_valid) begin
        q[wp] <= res;
        wp <= wp + 2'd1;
      end
      if (m_tvalid && m_tready) begin
        sub <= m_last ? 2'd0 : sub + 2'd1;
      end
      if (pop) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + 3'(res_valid) - 3'(pop);
    end
  end

  `BCJ_ASSERT_IMP(a_no_overflow, clk, rst, res_valid, cnt != 3'd4, "result queue overflow")
  `BCJ_ASSERT_IMP(a_sub_zero, clk, rst, m_tvalid && !h.four, sub == 2'd0, "serializer misaligned")
  `BCJ_ASSERT_NEXT(a_valid_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "output word withdrawn")
endmodule

// ===== rtl/core/bcj2_branch_decoder.sv =====
// Top level of the x86 branch filter decoder; depends on bcj_pkg, bcj_core and bcj_back.
// After reset the probability table's 258 entries are filled while s_tready is low.
// A main byte, a prologue byte, a target word or any rejected word leaves the core ready
// for the next word, room in the queue permitting. A word that decodes a branch bit (a
// candidate main byte while the range is wide, or the range byte that renormalizes it)
// holds s_tready low while the table read and the multiply are each registered before
// the compare. Each result is registered in the core and then written into the queue
// before it is offered. A target word gives four output words, so output bandwidth bounds
// a run of them, and the input stalls while three or more results wait in the queue.
module bcj2_branch_decoder #(
  parameter int PROB_BITS = 11,
  parameter int MOVE_BITS = 5
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [39:0] s_tdata,  // in_byte[7:0], target_word[39:8]
  input  logic [1:0] s_tuser,   // opcode
  output logic m_tvalid,
  input  logic m_tready,
  output logic [15:0] m_tdata,  // out_byte[7:0], out_valid[8], need_next[10:9], status[13:11]
  output logic m_tlast
);
  import bcj_pkg::*;

  logic [31:0] output_length;
  item_t item;
  res_t res;
  logic res_valid, res_room;
  logic [7:0] ob;
  logic ov;
  logic [1:0] nn;
  logic [2:0] st;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= '0;
    end else if (cfg_valid) begin
      output_length <= cfg_data;
    end
  end

  assign item.opcode = s_tuser;
  assign item.in_byte = s_tdata[7:0];
  assign item.target_word = s_tdata[39:8];

  bcj_core #(.PROB_BITS(PROB_BITS), .MOVE_BITS(MOVE_BITS)) u_core (
    .clk(clk), .rst(rst), .output_length(output_length),
    .in_valid(s_tvalid), .in_ready(s_tready), .item(item),
    .res_valid(res_valid), .res_room(res_room), .res(res)
  );

  bcj_back u_back (
    .clk(clk), .rst(rst), .res_valid(res_valid), .res_room(res_room), .res(res),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_byte(ob), .m_out_valid(ov),
    .m_last(m_tlast), .m_need(nn), .m_status(st)
  );

  assign m_tdata = {2'b00, st, nn, ov, ob};
endmodule
